[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. Each use names the clock and
// the active-low synchronous reset of the module that asserts.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/htsp_pkg.sv]
// ---------------------------------------------------------------------------
// htsp_pkg
// Types and constants for the humidity and temperature sensor poller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htsp_pkg;

  localparam logic [7:0] CMD_SOFT_RESET = 8'hFE;
  localparam logic [7:0] CMD_TEMP       = 8'hF3;
  localparam logic [7:0] CMD_HUMID      = 8'hF5;
  localparam logic [7:0] CMD_NONE       = 8'h00;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TEMP  = 2'd2;
  localparam logic [1:0] KIND_HUMID = 2'd3;

  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_TEMP_WAIT     = 2'd1;
  localparam logic [1:0] CFG_HUMID_WAIT    = 2'd2;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd21094;
  localparam logic [7:0]  TEMP_WAIT_RST     = 8'd50;
  localparam logic [7:0]  HUMID_WAIT_RST    = 8'd16;

  localparam logic [14:0] TEMP_SCALE   = 15'd17572;
  localparam logic [14:0] HUMID_SCALE  = 15'd1250;
  localparam logic [15:0] TEMP_OFFSET  = 16'd4685;
  localparam logic [15:0] HUMID_OFFSET = 16'd60;
  localparam logic [7:0]  LOW_MASK     = 8'hFC;

  typedef enum logic [7:0] {
    PH_IDLE_TEMP = 8'b0000_0001,
    PH_TEMP_CMD  = 8'b0000_0010,
    PH_TEMP_WAIT = 8'b0000_0100,
    PH_TEMP_READ = 8'b0000_1000,
    PH_HUM_CMD   = 8'b0001_0000,
    PH_HUM_WAIT  = 8'b0010_0000,
    PH_HUM_READ  = 8'b0100_0000,
    PH_RESETTING = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         command;
    logic signed [14:0] reading;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

[rtl/humidity_temp_sensor_poller_unit.sv]
// ---------------------------------------------------------------------------
// humidity_temp_sensor_poller_unit
// Poll sequencer for a combined humidity and temperature sensor on a
// two-wire bus, with conversion of the readings to fixed-point units.
// ---------------------------------------------------------------------------
// The results of an accepted transaction are written into the registers of
// the result queue. Throughput: one input transaction per cycle; the
// four-entry result queue stalls the input when fewer than two entries are
// free. Reset clears the phase, countdown and queue and restores the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module humidity_temp_sensor_poller_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic               in_ok,
  input  wire logic [7:0]         in_data_high,
  input  wire logic [7:0]         in_data_low,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_command,
  output logic signed [14:0]      out_reading,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic [15:0] poll_r;
  logic [7:0]  twait_r;
  logic [7:0]  hwait_r;

  htsp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] countdown_r, countdown_nxt;

  htsp_pkg::result_t fifo_r [4];
  logic [1:0] head_r, tail_r;
  logic [2:0] cnt_r, cnt_nxt;

  logic in_acc, out_acc;
  logic [1:0] push_n;
  htsp_pkg::result_t res0, res1;

  logic [15:0] raw;
  logic [14:0] scale;
  logic [15:0] offset;
  logic [30:0] product;
  logic [15:0] conv;
  logic [15:0] cd_dec;
  logic        is_wait;

  assign cfg_ready = 1'b1;
  assign in_stall  = (cnt_r > 3'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  assign out_kind    = fifo_r[head_r].kind;
  assign out_command = fifo_r[head_r].command;
  assign out_reading = fifo_r[head_r].reading;
  assign out_last    = fifo_r[head_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r  <= htsp_pkg::POLL_INTERVAL_RST;
      twait_r <= htsp_pkg::TEMP_WAIT_RST;
      hwait_r <= htsp_pkg::HUMID_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        htsp_pkg::CFG_POLL_INTERVAL: poll_r  <= cfg_data;
        htsp_pkg::CFG_TEMP_WAIT:     twait_r <= cfg_data[7:0];
        htsp_pkg::CFG_HUMID_WAIT:    hwait_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign raw     = {in_data_high, in_data_low & htsp_pkg::LOW_MASK};
  assign scale   = (phase_r == htsp_pkg::PH_HUM_READ) ? htsp_pkg::HUMID_SCALE
                                                      : htsp_pkg::TEMP_SCALE;
  assign offset  = (phase_r == htsp_pkg::PH_HUM_READ) ? htsp_pkg::HUMID_OFFSET
                                                      : htsp_pkg::TEMP_OFFSET;
  assign product = 31'(raw) * 31'(scale);
  assign conv    = {1'b0, product[30:16]} - offset;
  assign cd_dec  = (countdown_r != 16'd0) ? countdown_r - 16'd1 : 16'd0;
  assign is_wait = (phase_r == htsp_pkg::PH_IDLE_TEMP) ||
                   (phase_r == htsp_pkg::PH_TEMP_WAIT) ||
                   (phase_r == htsp_pkg::PH_HUM_WAIT);

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    push_n        = 2'd0;
    res0          = '{kind: htsp_pkg::KIND_WRITE, command: htsp_pkg::CMD_NONE,
                      reading: 15'sd0, last: 1'b1};
    res1          = res0;
    if (!in_func) begin
      if (is_wait) begin
        countdown_nxt = cd_dec;
        if (cd_dec == 16'd0) begin
          push_n = 2'd1;
          if (phase_r == htsp_pkg::PH_IDLE_TEMP) begin
            res0.command = htsp_pkg::CMD_TEMP;
            phase_nxt    = htsp_pkg::PH_TEMP_CMD;
          end else begin
            res0.kind = htsp_pkg::KIND_READ;
            phase_nxt = (phase_r == htsp_pkg::PH_TEMP_WAIT) ? htsp_pkg::PH_TEMP_READ
                                                            : htsp_pkg::PH_HUM_READ;
          end
        end
      end
    end else begin
      case (phase_r)
        htsp_pkg::PH_TEMP_CMD, htsp_pkg::PH_HUM_CMD: begin
          if (!in_ok) begin
            push_n        = 2'd1;
            res0.command  = htsp_pkg::CMD_SOFT_RESET;
            phase_nxt     = htsp_pkg::PH_RESETTING;
            countdown_nxt = 16'd0;
          end else if (phase_r == htsp_pkg::PH_TEMP_CMD) begin
            countdown_nxt = {8'd0, twait_r};
            phase_nxt     = htsp_pkg::PH_TEMP_WAIT;
          end else begin
            countdown_nxt = {8'd0, hwait_r};
            phase_nxt     = htsp_pkg::PH_HUM_WAIT;
          end
        end
        htsp_pkg::PH_TEMP_READ: begin
          push_n = 2'd1;
          if (!in_ok || in_data_low[1]) begin
            res0.command  = htsp_pkg::CMD_SOFT_RESET;
            phase_nxt     = htsp_pkg::PH_RESETTING;
            countdown_nxt = 16'd0;
          end else begin
            push_n       = 2'd2;
            res0.kind    = htsp_pkg::KIND_TEMP;
            res0.reading = signed'(conv[14:0]);
            res0.last    = 1'b0;
            res1.command = htsp_pkg::CMD_HUMID;
            phase_nxt    = htsp_pkg::PH_HUM_CMD;
          end
        end
        htsp_pkg::PH_HUM_READ: begin
          push_n = 2'd1;
          if (!in_ok || !in_data_low[1]) begin
            res0.command  = htsp_pkg::CMD_SOFT_RESET;
            phase_nxt     = htsp_pkg::PH_RESETTING;
            countdown_nxt = 16'd0;
          end else begin
            res0.kind     = htsp_pkg::KIND_HUMID;
            res0.reading  = signed'(conv[14:0]);
            countdown_nxt = poll_r;
            phase_nxt     = htsp_pkg::PH_IDLE_TEMP;
          end
        end
        htsp_pkg::PH_RESETTING: begin
          countdown_nxt = poll_r;
          phase_nxt     = htsp_pkg::PH_IDLE_TEMP;
        end
        default: ;
      endcase
    end
  end

  assign cnt_nxt = cnt_r + (in_acc ? {1'b0, push_n} : 3'd0) - {2'd0, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= htsp_pkg::PH_IDLE_TEMP;
      countdown_r <= 16'd0;
      head_r      <= 2'd0;
      tail_r      <= 2'd0;
      cnt_r       <= 3'd0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        countdown_r <= countdown_nxt;
        tail_r      <= tail_r + push_n;
      end
      if (out_acc) begin
        head_r <= head_r + 2'd1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (push_n != 2'd0)) begin
      fifo_r[tail_r] <= res0;
    end
    if (in_acc && (push_n == 2'd2)) begin
      fifo_r[tail_r + 2'd1] <= res1;
    end
  end

  `ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 3'd4)
  `ASSERT_SAME(a_room_on_accept, clk, rst_n, in_acc, cnt_r <= 3'd2)
  `ASSERT_SAME(a_pair_first_not_last, clk, rst_n, in_acc && (push_n == 2'd2), !res0.last)
  `ASSERT_SAME(a_busy_no_countdown, clk, rst_n, !is_wait, countdown_r == 16'd0)

endmodule

`default_nettype wire
